FILE: hdl/open_addressing_hash_table_unit_macros.svh
// Assertion macros for the open addressing hash table unit.
// Included by the controller and the datapath; depends on nothing.
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under an active-low synchronous reset.
`define OAHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// Next-cycle implication under an active-low synchronous reset.
`define OAHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define OAHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OAHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/oaht_pkg.sv
// Shared types and constants of the open addressing hash table unit.
// Depends on nothing; used by every module of the block.
`default_nettype none
package oaht_pkg;

    // Table geometry
    localparam int TABLE_SIZE  = 7;
    localparam int KEY_WIDTH   = 16;
    localparam int KEY_FIELD_W = 16;
    localparam int SLOT_IDX_W  = 3;
    localparam int KEY_KEEP_W  = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
    localparam int SLOT_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    // Double hashing prime and its residue width
    localparam int DH_PRIME = 11;
    localparam int DH_W     = $clog2(DH_PRIME);

    // Reciprocal constants for the constant modulo (floor(2^32 / m))
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = KEY_KEEP_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP_TS =
        RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / TABLE_SIZE);
    localparam logic [RECIP_SHIFT-1:0] RECIP_DH =
        RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / DH_PRIME);

    // Working width of the remainder correction
    localparam int RED_W = (KEY_KEEP_W > 8) ? KEY_KEEP_W : 8;

    // Double hashing stride (DH_PRIME - key mod DH_PRIME) mod TABLE_SIZE
    localparam logic [SLOT_W-1:0] DH_STRIDE [DH_PRIME] = '{
        SLOT_W'((DH_PRIME - 0)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 1)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 2)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 3)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 4)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 5)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 6)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 7)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 8)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 9)  % TABLE_SIZE),
        SLOT_W'((DH_PRIME - 10) % TABLE_SIZE)
    };

    // Quadratic probe: the offset step grows by two each probe
    localparam logic [SLOT_W-1:0] QUAD_INC = SLOT_W'(2 % TABLE_SIZE);

    typedef enum logic [1:0] {
        PM_LINEAR    = 2'd0,
        PM_QUADRATIC = 2'd1,
        PM_DOUBLE    = 2'd2
    } t_probe_mode;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_action                 action;
        logic [KEY_FIELD_W-1:0]  key_value;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_IDX_W-1:0]   slot_index;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic hash;
        logic advance;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: hdl/oaht_ctrl.sv
// Sequencing state machine of the hash table unit.
// Depends on oaht_pkg and the assertion macro header.
`default_nettype none
`include "open_addressing_hash_table_unit_macros.svh"
module oaht_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire oaht_pkg::t_dp_stat i_stat,
    output oaht_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_HASH  = 3'b010,
        S_PROBE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // take no transfer while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.hit || i_stat.last) begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.commit || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `OAHT_ASSERT_IMP(a_commit_free, i_clk, i_rst_n, o_cmd.commit, !r_out_valid || i_out_ready)
    `OAHT_ASSERT_NXT(a_accept_hash, i_clk, i_rst_n, o_cmd.accept, r_state == S_HASH)
    `OAHT_ASSERT_IMP(a_state_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))

endmodule
`default_nettype wire

FILE: hdl/oaht_dpath.sv
// Datapath of the hash table unit: slot store, home and stride hashing, probe walk.
// Depends on oaht_pkg and the assertion macro header.
`default_nettype none
`include "open_addressing_hash_table_unit_macros.svh"
module oaht_dpath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_data,
    input  wire oaht_pkg::t_in_item    i_in_data,
    input  wire oaht_pkg::t_dp_cmd     i_cmd,
    output oaht_pkg::t_dp_stat         o_stat,
    output oaht_pkg::t_out_item        o_out_data
);

    localparam int N  = oaht_pkg::TABLE_SIZE;
    localparam int SW = oaht_pkg::SLOT_W;
    localparam int KW = oaht_pkg::KEY_KEEP_W;
    localparam int RW = oaht_pkg::RED_W;
    localparam int PW = oaht_pkg::PROD_W;
    localparam int RS = oaht_pkg::RECIP_SHIFT;

    // Add two residues below N and fold once
    function automatic logic [SW-1:0] add_mod(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SW+1)'(N)) begin
            sum = sum - (SW+1)'(N);
        end
        return sum[SW-1:0];
    endfunction

    // Estimated remainder lies below twice the modulus: fold once
    function automatic logic [RW-1:0] fix_rem(input logic [RW-1:0] r_est,
                                              input logic [RW-1:0] modulus);
        return (r_est >= modulus) ? (r_est - modulus) : r_est;
    endfunction

    logic [1:0]                r_mode;
    oaht_pkg::t_action         r_action;
    logic [KW-1:0]             r_key;
    logic [PW-1:0]             r_prod_ts;
    logic [PW-1:0]             r_prod_dh;
    logic [SW-1:0]             r_pos;
    logic [SW-1:0]             r_step;
    logic [SW-1:0]             r_cnt;
    logic [N-1:0]              r_occ;
    logic [KW-1:0]             r_slot_key [N];
    oaht_pkg::t_out_item       r_out_data;

    logic [KW-1:0]             in_key;
    logic [RW-1:0]             rem_ts;
    logic [RW-1:0]             rem_dh;
    logic [SW-1:0]             init_step;
    logic [SW-1:0]             next_step;
    logic                      commit_ins;
    logic                      commit_del;

    assign in_key = i_in_data.key_value[KW-1:0];

    // Remainders from the registered reciprocal products
    assign rem_ts = fix_rem(RW'(r_key) - RW'(r_prod_ts[PW-1:RS]) * RW'(N), RW'(N));
    assign rem_dh = fix_rem(RW'(r_key) - RW'(r_prod_dh[PW-1:RS]) * RW'(oaht_pkg::DH_PRIME),
                            RW'(oaht_pkg::DH_PRIME));

    always_comb begin
        init_step = SW'(1);
        next_step = r_step;
        unique case (r_mode)
            oaht_pkg::PM_QUADRATIC: begin
                next_step = add_mod(r_step, oaht_pkg::QUAD_INC);
            end
            oaht_pkg::PM_DOUBLE: begin
                init_step = oaht_pkg::DH_STRIDE[rem_dh[oaht_pkg::DH_W-1:0]];
            end
            default: begin
                init_step = SW'(1);
            end
        endcase
    end

    // Probe verdict at the current position
    always_comb begin
        o_stat.last = (r_cnt == SW'(N - 1));
        if (r_action == oaht_pkg::ACT_INSERT) begin
            o_stat.hit = !r_occ[r_pos];
        end else begin
            o_stat.hit = r_occ[r_pos] && (r_slot_key[r_pos] == r_key);
        end
    end

    assign commit_ins = i_cmd.commit && o_stat.hit && r_action == oaht_pkg::ACT_INSERT;
    assign commit_del = i_cmd.commit && o_stat.hit && r_action == oaht_pkg::ACT_DELETE;

    // Control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'(oaht_pkg::PM_LINEAR);
            r_occ  <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.hash) begin
                r_pos <= rem_ts[SW-1:0];
                r_cnt <= '0;
            end else if (i_cmd.advance) begin
                r_pos <= add_mod(r_pos, r_step);
                r_cnt <= r_cnt + SW'(1);
            end
            if (i_cmd.commit && o_stat.hit) begin
                r_occ[r_pos] <= (r_action == oaht_pkg::ACT_INSERT);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action  <= i_in_data.action;
            r_key     <= in_key;
            r_prod_ts <= PW'(in_key) * PW'(oaht_pkg::RECIP_TS);
            r_prod_dh <= PW'(in_key) * PW'(oaht_pkg::RECIP_DH);
        end
        if (i_cmd.hash) begin
            r_step <= init_step;
        end else if (i_cmd.advance) begin
            r_step <= next_step;
        end
        if (i_cmd.commit && o_stat.hit && r_action == oaht_pkg::ACT_INSERT) begin
            r_slot_key[r_pos] <= r_key;
        end
        if (i_cmd.commit) begin
            if (o_stat.hit) begin
                r_out_data.status     <= oaht_pkg::ST_DONE;
                r_out_data.slot_index <= oaht_pkg::SLOT_IDX_W'(r_pos);
            end else begin
                r_out_data.status     <= (r_action == oaht_pkg::ACT_INSERT) ?
                                         oaht_pkg::ST_FULL : oaht_pkg::ST_NOT_FOUND;
                r_out_data.slot_index <= '0;
            end
        end
    end

    assign o_out_data = r_out_data;

    `OAHT_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= SW'(N - 1))
    `OAHT_ASSERT_NXT(a_ins_marks, i_clk, i_rst_n, commit_ins, r_occ[$past(r_pos)])
    `OAHT_ASSERT_NXT(a_del_frees, i_clk, i_rst_n, commit_del, !r_occ[$past(r_pos)])

endmodule
`default_nettype wire

FILE: hdl/open_addressing_hash_table_unit.sv
// Flow: one transfer in, a hash step, then a probe walk over up to TABLE_SIZE slots, one slot per probe;
// the deciding probe commits the result into an output register once that register is free.
// A new item is taken only after the previous one has committed; while a result waits in the
// output register it blocks only the commit of the next item, not its hashing or probe walk.
// Reset: all slots empty, probe mode linear, no clearing pass; keys are undefined until written.
`default_nettype none
module open_addressing_hash_table_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire oaht_pkg::t_in_item    i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output oaht_pkg::t_out_item        o_out_data,
    // probe mode register write
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_data
);

    oaht_pkg::t_dp_cmd  cmd;
    oaht_pkg::t_dp_stat stat;

    // Configuration writes go straight into the probe mode register; take the transfer whenever out of reset.
    assign o_cfg_ready = i_rst_n;

    // Controller: idle -> hash -> probe walk; commit once the output register frees up.
    oaht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: reciprocal hashing, incremental probe position, slot flags and keys.
    oaht_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

FILE: verif/open_addressing_hash_table_unit_tb.sv
// Self-checking testbench for the open addressing hash table unit.
// Depends on oaht_pkg and the open_addressing_hash_table_unit RTL.
// Predicts each insert/delete outcome from a shadow table and checks every result transfer.
`default_nettype none
module open_addressing_hash_table_unit_tb;
    import oaht_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    // idle cycles before a probe mode write, comfortably past the longest probe walk
    localparam int CFG_SETTLE  = TABLE_SIZE + 8;
    localparam int END_SETTLE  = 2 * TABLE_SIZE + 6;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int POOL_SIZE   = 8;

    typedef enum logic [1:0] {
        EV_ITEM,
        EV_PROBE_CFG,
        EV_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind  kind;
        t_in_item    item;
        logic [1:0]  mode;
        int          gap;
    } t_stim;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        o_cfg_ready;

    open_addressing_hash_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // shadow of the block's table and probe mode
    logic                  shadow_used [TABLE_SIZE];
    logic [KEY_WIDTH-1:0]  shadow_keys [TABLE_SIZE];
    logic [1:0]            shadow_mode = PM_LINEAR;

    t_stim      pending_ops[$];
    t_out_item  expected_results[$];

    int   cycle_count  = 0;
    int   err_count    = 0;
    int   idle_cycles  = 0;
    int   wait_cnt     = 0;
    int   stall_left   = 0;
    int   results_seen = 0;
    logic recv_quiet   = 1'b0;
    logic in_fired     = 1'b0;
    logic cfg_fired    = 1'b0;
    logic out_fired    = 1'b0;

    // Walk the probe sequence of one item over the shadow table and update it.
    function automatic t_out_item predict_table_op(t_in_item op);
        t_out_item            res;
        logic [KEY_WIDTH-1:0] k;
        int                   home;
        int                   stride;
        int                   p;
        k = op.key_value[KEY_WIDTH-1:0];
        home = int'(k) % TABLE_SIZE;
        res.status = (op.action == ACT_DELETE) ? ST_NOT_FOUND : ST_FULL;
        res.slot_index = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (shadow_mode == PM_QUADRATIC)
                stride = i * i;
            else if (shadow_mode == PM_DOUBLE)
                stride = i * (DH_PRIME - (int'(k) % DH_PRIME));
            else
                stride = i;   // linear, and the unused mode too
            p = (home + stride) % TABLE_SIZE;
            if (op.action == ACT_INSERT && !shadow_used[p]) begin
                shadow_used[p] = 1'b1;
                shadow_keys[p] = k;
                res.status = ST_DONE;
                res.slot_index = SLOT_IDX_W'(p);
                break;
            end
            if (op.action == ACT_DELETE && shadow_used[p] && shadow_keys[p] == k) begin
                shadow_used[p] = 1'b0;
                res.status = ST_DONE;
                res.slot_index = SLOT_IDX_W'(p);
                break;
            end
        end
        return res;
    endfunction

    task automatic push_op(input t_action act, input logic [15:0] key, input int gap);
        t_stim s;
        s.kind = EV_ITEM;
        s.item.action = act;
        s.item.key_value = key;
        s.mode = '0;
        s.gap = gap;
        pending_ops.push_back(s);
    endtask

    task automatic push_marker(input t_stim_kind kind, input logic [1:0] mode);
        t_stim s;
        s.kind = kind;
        s.item = '0;
        s.mode = mode;
        s.gap = 0;
        pending_ops.push_back(s);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: sample every handshake at the rising edge and check results.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("open_addressing_hash_table_unit_tb: FAIL");
            $finish;
        end else if (!i_rst_n) begin
            in_fired = 1'b0;
            cfg_fired = 1'b0;
            out_fired = 1'b0;
            idle_cycles = 0;
        end else begin
            in_fired = in_valid && o_in_ready;
            cfg_fired = cfg_valid && o_cfg_ready;
            out_fired = out_ready && o_out_valid;
            // check the result before adding this edge's prediction
            if (out_fired) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d, slot_index %0d",
                           o_out_data.status, o_out_data.slot_index);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, o_out_data.status);
                        err_count++;
                    end
                    if (o_out_data.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, o_out_data.slot_index);
                        err_count++;
                    end
                end
            end
            if (cfg_fired)
                shadow_mode = cfg_data;
            if (in_fired)
                expected_results.push_back(predict_table_op(in_data));
            if (expected_results.size() == 0 && !in_valid && !cfg_valid)
                idle_cycles++;
            else
                idle_cycles = 0;
        end
    end

    // Driver: feed the item and probe mode channels from the pending queue.
    always @(negedge i_clk) begin : driver
        logic nxt_valid;
        logic nxt_cfg;
        nxt_valid = in_valid && !in_fired;
        nxt_cfg = cfg_valid && !cfg_fired;
        if (i_rst_n && !nxt_valid && !nxt_cfg && pending_ops.size() > 0) begin
            case (pending_ops[0].kind)
                EV_ITEM: begin
                    if (wait_cnt >= pending_ops[0].gap) begin
                        nxt_valid = 1'b1;
                        in_data <= pending_ops[0].item;
                        void'(pending_ops.pop_front());
                        wait_cnt = 0;
                    end else begin
                        wait_cnt++;
                    end
                end
                EV_PROBE_CFG: begin
                    // hold the write until the block has been quiet for a while
                    if (idle_cycles >= CFG_SETTLE) begin
                        nxt_cfg = 1'b1;
                        cfg_data <= pending_ops[0].mode;
                        void'(pending_ops.pop_front());
                        wait_cnt = 0;
                    end
                end
                default: begin
                    // drain: hold the sender until every result is back
                    if (idle_cycles > 0)
                        void'(pending_ops.pop_front());
                end
            endcase
        end
        in_valid <= nxt_valid;
        cfg_valid <= nxt_cfg;
    end

    // Receiver: stall for a random count after each result transfer, or not at all in quiet stretches.
    always @(negedge i_clk) begin : receiver
        if (out_fired) begin
            results_seen++;
            if (results_seen % 40 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            stall_left = recv_quiet ? 0 : $urandom_range(0, 15);
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [15:0] pool [POOL_SIZE];
        int          rot;
        int          ins_pct;
        int          drain_at;
        logic        quiet;
        logic [15:0] key;
        t_action     act;

        for (int s = 0; s < TABLE_SIZE; s++) begin
            shadow_used[s] = 1'b0;
            shadow_keys[s] = '0;
        end

        // Directed: fill every slot first so no unwritten key is ever compared.
        push_op(ACT_INSERT, 16'h0000, $urandom_range(0, 15));
        push_op(ACT_INSERT, 16'hFFFF, $urandom_range(0, 15));
        push_op(ACT_INSERT, 16'd7,    0);
        push_op(ACT_INSERT, 16'd14,   0);
        push_op(ACT_INSERT, 16'd21,   $urandom_range(0, 15));
        push_op(ACT_INSERT, 16'h8000, 0);
        push_op(ACT_INSERT, 16'h5555, 0);
        push_op(ACT_INSERT, 16'd5,    0);     // table full
        push_op(ACT_DELETE, 16'hAAAA, 0);     // not found
        push_op(ACT_DELETE, 16'd14,   0);
        push_op(ACT_DELETE, 16'd21,   0);     // search runs past the freed slot
        push_op(ACT_INSERT, 16'd7,    0);     // second copy of a stored key
        push_op(ACT_DELETE, 16'd7,    0);
        push_op(ACT_DELETE, 16'd7,    0);
        push_op(ACT_DELETE, 16'd7,    0);     // both copies gone
        push_marker(EV_PROBE_CFG, 2'd3);      // unused mode acts as linear
        push_op(ACT_INSERT, 16'd28,   0);
        push_op(ACT_DELETE, 16'd28,   0);
        push_marker(EV_PROBE_CFG, PM_QUADRATIC);
        push_op(ACT_INSERT, 16'd35,   0);
        push_op(ACT_INSERT, 16'd42,   0);
        push_op(ACT_INSERT, 16'd49,   0);     // quadratic walk misses free slots
        push_marker(EV_DRAIN, '0);
        push_marker(EV_PROBE_CFG, PM_DOUBLE);
        push_op(ACT_DELETE, 16'd35,   0);
        push_op(ACT_INSERT, 16'd4,    0);     // stride of a whole table: one slot only
        push_op(ACT_INSERT, 16'd4,    0);
        push_op(ACT_DELETE, 16'hFFFF, 0);

        // Random phases, each under its own probe mode.
        rot = $urandom_range(0, 3);
        for (int ph = 0; ph < PHASES; ph++) begin
            push_marker(EV_PROBE_CFG, 2'((ph + rot) % 4));
            quiet = (ph == 2 || ph == 5);
            ins_pct = $urandom_range(30, 70);
            drain_at = $urandom_range(10, PHASE_ITEMS - 10);
            // half the pool shares one home slot to force long probe walks
            key = 16'($urandom_range(0, TABLE_SIZE - 1));
            for (int j = 0; j < POOL_SIZE; j++) begin
                if (j % 2 == 0)
                    pool[j] = 16'($urandom_range(0, 9000) * TABLE_SIZE) + key;
                else
                    pool[j] = 16'($urandom_range(0, 16'hFFFF));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == drain_at)
                    push_marker(EV_DRAIN, '0);
                act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_DELETE;
                if ($urandom_range(0, 99) < 85)
                    key = pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    key = 16'($urandom_range(0, 16'hFFFF));
                push_op(act, key, quiet ? 0 : $urandom_range(0, 15));
            end
        end
        push_marker(EV_PROBE_CFG, PM_LINEAR);

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_ops.size() != 0 || in_valid || cfg_valid
               || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (END_SETTLE) @(negedge i_clk);

        if (err_count == 0)
            $display("open_addressing_hash_table_unit_tb: PASS");
        else
            $display("open_addressing_hash_table_unit_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/oaht_pkg.sv
hdl/oaht_ctrl.sv
hdl/oaht_dpath.sv
hdl/open_addressing_hash_table_unit.sv
verif/open_addressing_hash_table_unit_tb.sv
